// ===== sv/rgb12_histogram_auto_levels_macros.svh =====
// Assertion macros shared by the auto-levels block.
`ifndef RGB12_HISTOGRAM_AUTO_LEVELS_MACROS_SVH
`define RGB12_HISTOGRAM_AUTO_LEVELS_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RGBHAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RGBHAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rgbhal_pkg.sv =====
// Shared types and constants of the auto-levels block.
package rgbhal_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int OUT_W     = 12;
  localparam int TAIL_W    = 14;
  localparam int SHIFT_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 14;
  localparam int TAIL_DIV  = 10000;
  localparam int CH_N      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_TAIL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TAIL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SHIFT = 2'd2;

  localparam logic [TAIL_W-1:0] LOW_TAIL_RST  = 14'd100;
  localparam logic [TAIL_W-1:0] HIGH_TAIL_RST = 14'd100;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;       // write zero to bin at sweep pointer, advance pointer
    logic clr_pix;      // clear the pixel count and rewind the sweep pointer
    logic cap_in;       // capture the input request
    logic hist_rd;      // read bin of the selected sample
    logic hist_wr;      // write back incremented bin, advance sample select
    logic pix_inc;      // count the pixel
    logic lim_mul_lo;   // tail product for the dark tail
    logic lim_mul_hi;   // tail product for the bright tail
    logic div_start;    // start the gain divider
    logic scan_init_lo; // start the upward bin scan
    logic scan_init_hi; // start the downward bin scan
    logic scan_rd;      // read bin at scan pointer
    logic scan_acc_lo;  // accumulate, step up or settle low point
    logic scan_acc_hi;  // accumulate, step down or settle high point
    logic span_load;    // form the span
    logic gain_load;    // take quotient as gain, commit low point
    logic map_mul;      // multiply the three sample offsets from the low point by the gain
    logic out_load;     // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_end;
    logic sel_last;
    logic pix_full;
    logic last_pix;
    logic div_busy;
    logic scan_stop_lo;
    logic scan_stop_hi;
  } sts_t;

endpackage

// ===== sv/rgbhal_div.sv =====
// Restoring divider, one quotient bit per cycle.
module rgbhal_div #(
  parameter int NW = 41,
  parameter int DW = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quotient
);

  localparam int CNW = $clog2(NW + 1);

  logic [DW:0]    rem;
  logic [NW-1:0]  quo;
  logic [DW-1:0]  dsr;
  logic [CNW-1:0] cnt;
  logic [DW:0]    rem_sh;
  logic           ge;

  always_comb begin
    rem_sh = {rem[DW-1:0], quo[NW-1]};
    ge     = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNW'(NW);
    end else if (busy) begin
      cnt <= cnt - CNW'(1);
      if (cnt == CNW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? (rem_sh - {1'b0, dsr}) : rem_sh;
      quo <= {quo[NW-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// ===== sv/rgbhal_datapath.sv =====
// Datapath: histogram memory, bin scan, stretch points, gain and mapping.
module rgbhal_datapath #(
  parameter int BIN_COUNT  = 4096,
  parameter int MAX_PIXELS = 1048576
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rgbhal_pkg::cmd_t                    cmd,
  output rgbhal_pkg::sts_t                    sts,
  input  logic                                cfg_we,
  input  logic [rgbhal_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgbhal_pkg::CFG_W-1:0]        cfg_data,
  input  logic signed [rgbhal_pkg::SAMPLE_W-1:0] red_sample,
  input  logic signed [rgbhal_pkg::SAMPLE_W-1:0] green_sample,
  input  logic signed [rgbhal_pkg::SAMPLE_W-1:0] blue_sample,
  input  logic                                last_pixel,
  output logic [rgbhal_pkg::OUT_W-1:0]        red_out,
  output logic [rgbhal_pkg::OUT_W-1:0]        green_out,
  output logic [rgbhal_pkg::OUT_W-1:0]        blue_out,
  output logic                                last_out
);
  import rgbhal_pkg::*;

  localparam int BW   = $clog2(BIN_COUNT);
  localparam int PCW  = $clog2(MAX_PIXELS + 1);
  localparam int CW   = $clog2(3 * MAX_PIXELS + 1);
  localparam int SMW  = PCW + 2;
  localparam int PW   = SMW + TAIL_W;
  localparam int GW   = BW + 16;
  localparam int DSW  = BW + 2;
  localparam int SPW  = ((BW > 12) ? BW : 12) + 2;
  localparam int XW   = ((SPW > SAMPLE_W) ? SPW : SAMPLE_W) + 1;
  localparam int PRW  = GW + 1 + XW;

  localparam logic [BW-1:0]         BIN_LAST  = BW'(BIN_COUNT - 1);
  localparam logic [BW-1:0]         BIN_ONE   = BW'(1);
  localparam logic [PCW-1:0]        PIX_MAX   = PCW'(MAX_PIXELS);
  localparam logic signed [SPW-1:0] ONE_S     = SPW'(1);
  localparam logic signed [SPW-1:0] LAST_S    = SPW'(BIN_COUNT - 1);
  localparam logic signed [SPW-1:0] TOP_S     = SPW'(BIN_COUNT);
  localparam logic [GW-1:0]         GAIN_NUM  = GW'(64'(BIN_COUNT - 1) << 16);
  localparam logic [PW-1:0]         TAIL_SCL  = PW'(TAIL_DIV);
  localparam logic [GW-1:0]         GAIN_UNIT = GW'(65536);

  // Configuration registers.
  logic [TAIL_W-1:0]  low_tail;
  logic [TAIL_W-1:0]  high_tail;
  logic [SHIFT_W-1:0] max_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_tail  <= LOW_TAIL_RST;
      high_tail <= HIGH_TAIL_RST;
      max_shift <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_TAIL:  low_tail  <= cfg_data[TAIL_W-1:0];
        REG_HIGH_TAIL: high_tail <= cfg_data[TAIL_W-1:0];
        REG_MAX_SHIFT: max_shift <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured request.
  logic signed [SAMPLE_W-1:0] x_r [CH_N];
  logic                       last_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      x_r[0] <= red_sample;
      x_r[1] <= green_sample;
      x_r[2] <= blue_sample;
      last_r <= last_pixel;
    end
  end

  // Control-side counters and committed stretch state.
  logic [1:0]              sel;
  logic [BW-1:0]           ptr;
  logic [PCW-1:0]          pixel_count;
  logic signed [SPW-1:0]   low_point;
  logic [GW-1:0]           gain;

  // Histogram memory.
  logic [CW-1:0] mem [BIN_COUNT];
  logic [CW-1:0] rdata;
  logic [BW-1:0] raddr;
  logic [BW-1:0] waddr;
  logic [CW-1:0] wdata;
  logic          mem_we;

  logic signed [SAMPLE_W-1:0] x_sel;
  logic [BW-1:0]              bin_sel;

  always_comb begin
    case (sel)
      2'd0:    x_sel = x_r[0];
      2'd1:    x_sel = x_r[1];
      default: x_sel = x_r[2];
    endcase
    if (x_sel[SAMPLE_W-1]) begin
      bin_sel = '0;
    end else if (32'(x_sel) > BIN_COUNT - 1) begin
      bin_sel = BIN_LAST;
    end else begin
      bin_sel = x_sel[BW-1:0];
    end
  end

  always_comb begin
    raddr  = cmd.hist_rd ? bin_sel : ptr;
    waddr  = cmd.clr_wr ? ptr : bin_sel;
    wdata  = cmd.clr_wr ? '0 : rdata + CW'(1);
    mem_we = cmd.clr_wr | cmd.hist_wr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Tail limit product. The scan compares the bin sum scaled by the tail
  // divisor against this product, which is the same test as comparing the
  // plain sum against the floored quotient.
  logic [SMW-1:0] samples;
  logic [PW-1:0]  lim_prod;
  logic [PW-1:0]  rdata_sc;
  logic [DSW-1:0] span_r;
  logic [GW-1:0]  div_q;
  logic           div_busy;

  assign samples = {pixel_count, 1'b0} + SMW'(pixel_count);

  always_ff @(posedge clk) begin
    if (cmd.lim_mul_lo) begin
      lim_prod <= PW'(samples) * PW'(low_tail);
    end else if (cmd.lim_mul_hi) begin
      lim_prod <= PW'(samples) * PW'(high_tail);
    end
    rdata_sc <= PW'(rdata) * TAIL_SCL;
  end

  rgbhal_div #(.NW(GW), .DW(DSW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (GAIN_NUM),
    .divisor  (span_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Bin scan.
  logic [PW-1:0]         sum;
  logic [PW-1:0]         sum_next;
  logic                  exceed;
  logic signed [SPW-1:0] ptr_s;
  logic signed [SPW-1:0] lim16_s;
  logic signed [SPW-1:0] a0_raw;
  logic signed [SPW-1:0] a1_raw;
  logic signed [SPW-1:0] a0_lim;
  logic signed [SPW-1:0] a1_lim;
  logic signed [SPW-1:0] hi_floor;
  logic signed [SPW-1:0] a0;
  logic signed [SPW-1:0] a1;
  logic signed [SPW:0]   span;

  always_comb begin
    sum_next = sum + rdata_sc;
    exceed   = sum_next > lim_prod;
    ptr_s    = $signed(SPW'(ptr));
    lim16_s  = $signed(SPW'({max_shift, 4'b0000}));
    hi_floor = TOP_S - lim16_s;
    a0_raw   = exceed ? ptr_s - ONE_S : LAST_S;
    a1_raw   = exceed ? ptr_s + ONE_S : ONE_S;
    a0_lim   = ((max_shift != '0) && (a0_raw > lim16_s)) ? lim16_s : a0_raw;
    a1_lim   = ((max_shift != '0) && (a1_raw < hi_floor)) ? hi_floor : a1_raw;
    span     = {a1[SPW-1], a1} - {a0[SPW-1], a0};
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init_lo || cmd.scan_init_hi) begin
      sum <= '0;
    end else if (cmd.scan_acc_lo || cmd.scan_acc_hi) begin
      sum <= sum_next;
    end
    if (cmd.scan_acc_lo && sts.scan_stop_lo) begin
      a0 <= a0_lim;
    end
    if (cmd.scan_acc_hi && sts.scan_stop_hi) begin
      a1 <= a1_lim;
    end
    if (cmd.span_load) begin
      // A span below one is forced to one.
      span_r <= (span[SPW] || (span == '0)) ? DSW'(1) : DSW'(span);
    end
  end

  // Counters and committed state.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel         <= '0;
      ptr         <= '0;
      pixel_count <= '0;
      low_point   <= '0;
      gain        <= GAIN_UNIT;
    end else begin
      if (cmd.cap_in) begin
        sel <= '0;
      end else if (cmd.hist_wr) begin
        sel <= sel + 2'd1;
      end
      if (cmd.clr_wr) begin
        ptr <= (ptr == BIN_LAST) ? '0 : ptr + BW'(1);
      end else if (cmd.clr_pix || cmd.scan_init_lo) begin
        ptr <= '0;
      end else if (cmd.scan_init_hi) begin
        ptr <= BIN_LAST;
      end else if (cmd.scan_acc_lo && !sts.scan_stop_lo) begin
        ptr <= ptr + BW'(1);
      end else if (cmd.scan_acc_hi && !sts.scan_stop_hi) begin
        ptr <= ptr - BW'(1);
      end
      if (cmd.clr_pix) begin
        pixel_count <= '0;
      end else if (cmd.pix_inc) begin
        pixel_count <= pixel_count + PCW'(1);
      end
      if (cmd.gain_load) begin
        gain      <= div_q;
        low_point <= a0;
      end
    end
  end

  // Mapping lanes: gain times offset, then clamp into the result register.
  logic signed [XW-1:0]  diff [CH_N];
  logic signed [PRW-1:0] prod [CH_N];
  logic [OUT_W-1:0]      mapped [CH_N];

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      diff[c] = $signed(XW'(x_r[c])) - $signed(XW'(low_point));
      if (prod[c][PRW-1] || (prod[c] == '0)) begin
        mapped[c] = '0;
      end else if (|prod[c][PRW-1:OUT_W+16]) begin
        mapped[c] = '1;
      end else begin
        mapped[c] = prod[c][OUT_W+15:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_mul) begin
      for (int c = 0; c < CH_N; c++) begin
        prod[c] <= $signed({1'b0, gain}) * diff[c];
      end
    end
    if (cmd.out_load) begin
      red_out   <= mapped[0];
      green_out <= mapped[1];
      blue_out  <= mapped[2];
      last_out  <= last_r;
    end
  end

  always_comb begin
    sts.sweep_end    = ptr == BIN_LAST;
    sts.sel_last     = sel == 2'd2;
    sts.pix_full     = pixel_count == PIX_MAX;
    sts.last_pix     = last_r;
    sts.div_busy     = div_busy;
    sts.scan_stop_lo = exceed || (ptr == BIN_LAST);
    sts.scan_stop_hi = exceed || (ptr == BIN_ONE);
  end

endmodule

// ===== sv/rgbhal_ctrl.sv =====
// Controller state machine of the auto-levels block.
`include "rgb12_histogram_auto_levels_macros.svh"

module rgbhal_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             operation,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output rgbhal_pkg::cmd_t cmd,
  input  rgbhal_pkg::sts_t sts
);
  import rgbhal_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_FCLR, S_RD, S_WR, S_POST,
    S_LMUL, S_LRD, S_LSC, S_LACC,
    S_HMUL, S_HRD, S_HSC, S_HACC,
    S_SPAN, S_GDIV0, S_GDIV, S_MAP, S_MOUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_apply;
  logic   in_apply_next;
  logic   accept;
  logic   out_free;

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    in_apply_next = in_apply;
    unique case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.sweep_end) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.cap_in = 1'b1;
          if (operation) begin
            state_next = S_MAP;
          end else if (in_apply) begin
            cmd.clr_pix   = 1'b1;
            in_apply_next = 1'b0;
            state_next    = S_FCLR;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_FCLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.sweep_end) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (sts.pix_full) begin
          state_next = S_POST;
        end else begin
          cmd.hist_rd = 1'b1;
          state_next  = S_WR;
        end
      end
      S_WR: begin
        cmd.hist_wr = 1'b1;
        if (sts.sel_last) begin
          cmd.pix_inc = 1'b1;
          state_next  = S_POST;
        end else begin
          state_next = S_RD;
        end
      end
      S_POST: begin
        state_next = sts.last_pix ? S_LMUL : S_IDLE;
      end
      S_LMUL: begin
        cmd.lim_mul_lo   = 1'b1;
        cmd.scan_init_lo = 1'b1;
        state_next       = S_LRD;
      end
      S_LRD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_LSC;
      end
      S_LSC: begin
        state_next = S_LACC;
      end
      S_LACC: begin
        cmd.scan_acc_lo = 1'b1;
        state_next      = sts.scan_stop_lo ? S_HMUL : S_LRD;
      end
      S_HMUL: begin
        cmd.lim_mul_hi   = 1'b1;
        cmd.scan_init_hi = 1'b1;
        state_next       = S_HRD;
      end
      S_HRD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_HSC;
      end
      S_HSC: begin
        state_next = S_HACC;
      end
      S_HACC: begin
        cmd.scan_acc_hi = 1'b1;
        state_next      = sts.scan_stop_hi ? S_SPAN : S_HRD;
      end
      S_SPAN: begin
        cmd.span_load = 1'b1;
        state_next    = S_GDIV0;
      end
      S_GDIV0: begin
        cmd.div_start = 1'b1;
        state_next    = S_GDIV;
      end
      S_GDIV: begin
        if (!sts.div_busy) begin
          cmd.gain_load = 1'b1;
          in_apply_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_MAP: begin
        cmd.map_mul = 1'b1;
        state_next  = S_MOUT;
      end
      S_MOUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      in_apply  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      in_apply <= in_apply_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `RGBHAL_ASSERT_NOW(a_wr_after_rd, cmd.hist_wr, $past(cmd.hist_rd), "bin write without read")
  `RGBHAL_ASSERT_NOW(a_div_idle, cmd.div_start, !sts.div_busy, "divider started while busy")
  `RGBHAL_ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "request accepted without work")
  `RGBHAL_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid || !out_stall, "result overwritten")

endmodule

// ===== sv/rgb12_histogram_auto_levels.sv =====
// Top level of the two-pass histogram auto-levels block for 12-bit RGB.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------------
//  input   | in_valid / in_stall    | operation, red/green/blue_sample, last_pixel
//  output  | out_valid / out_stall  | red_out, green_out, blue_out, last_out
//  config  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A histogram request makes three read-modify-write accesses to the bin memory,
// one per sample. An apply request runs through capture, gain multiply and clamp
// into the result register, and waits in its last step while a held result still
// occupies that register, with in_stall high. The end-of-frame computation is the
// two bin scans followed by one gain divider run. After reset, and on the first
// histogram request of a new frame, a clearing pass writes every bin.
module rgb12_histogram_auto_levels #(
  parameter int BIN_COUNT  = 4096,
  parameter int MAX_PIXELS = 1048576
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   operation,
  input  logic signed [rgbhal_pkg::SAMPLE_W-1:0] red_sample,
  input  logic signed [rgbhal_pkg::SAMPLE_W-1:0] green_sample,
  input  logic signed [rgbhal_pkg::SAMPLE_W-1:0] blue_sample,
  input  logic                                   last_pixel,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [rgbhal_pkg::OUT_W-1:0]           red_out,
  output logic [rgbhal_pkg::OUT_W-1:0]           green_out,
  output logic [rgbhal_pkg::OUT_W-1:0]           blue_out,
  output logic                                   last_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rgbhal_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rgbhal_pkg::CFG_W-1:0]           cfg_data
);
  import rgbhal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Register writes are always taken; the host is to write them only while the
  // block is idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  // The controller sequences every request and the end-of-frame computation.
  rgbhal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the histogram, the stretch points, the gain and the
  // result register.
  rgbhal_datapath #(
    .BIN_COUNT  (BIN_COUNT),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .red_sample   (red_sample),
    .green_sample (green_sample),
    .blue_sample  (blue_sample),
    .last_pixel   (last_pixel),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .last_out     (last_out)
  );

endmodule
